>>> hw/rtl/itpc_pkg.sv
// Shared constants, types and the operator ranking for the infix-to-postfix converter.
package itpc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_OPERAND = 8'h23;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_AND     = 8'h26;
  localparam logic [7:0] CH_XOR     = 8'h5E;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0] rank_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] token;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] postfix_char;
    logic       no_char;
    logic       overflow;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic rank_t rank_of(input logic [7:0] c);
    rank_t r;
    case (c)
      CH_AND:  r = 2'd3;
      CH_XOR:  r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/itpc_cell.sv
// One entry of the shifting operator stack.
module itpc_cell (
  input  logic               clk,
  input  itpc_pkg::stk_ctl_t ctl,
  input  logic [7:0]         above,
  input  logic [7:0]         below,
  output logic [7:0]         entry
);

  logic [7:0] entry_r;

  // A push moves every entry one place down, a pop one place up.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r <= above;
    end else if (ctl.pop) begin
      entry_r <= below;
    end
  end

  assign entry = entry_r;

endmodule

>>> hw/rtl/itpc_stack.sv
// Operator stack built as a chain of cells, with the top entry in the first cell.
module itpc_stack (
  input  logic               clk,
  input  itpc_pkg::stk_ctl_t ctl,
  input  logic [7:0]         push_char,
  output logic [7:0]         top_char,
  output logic [7:0]         second_char
);

  logic [7:0] entry_w [itpc_pkg::STACK_DEPTH];

  for (genvar i = 0; i < itpc_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [7:0] above_w;
    logic [7:0] below_w;

    if (i == 0) begin : g_first
      assign above_w = push_char;
    end else begin : g_mid_a
      assign above_w = entry_w[i-1];
    end

    if (i == itpc_pkg::STACK_DEPTH - 1) begin : g_end
      assign below_w = 8'h00;
    end else begin : g_mid_b
      assign below_w = entry_w[i+1];
    end

    itpc_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above_w),
      .below (below_w),
      .entry (entry_w[i])
    );
  end

  assign top_char    = entry_w[0];
  assign second_char = entry_w[1];

endmodule

>>> hw/rtl/infix_to_postfix_converter_unit.sv
// Top level of the infix-to-postfix converter: request sequencer, stack and output register.
//
// Infix characters arrive as requests on the in_ channel, one byte each, with
// end_of_expr marking the final byte of an expression. Postfix characters leave
// on the out_ channel, one request per emitted byte; the final request of an
// expression carries last, and an expression tail that emits nothing gives one
// request with no_char set. overflow reports the sticky full-stack flag.
// A request is taken only while the sequencer is idle. Each character is then
// accepted, pops stack entries one at a time, and finishes by pushing,
// dropping or emitting; an end character then flushes the remaining entries
// one at a time and closes. An operand is emitted from the work state into
// the output register once the output slot is free. The stack shifts by one
// entry per cycle when pushed or popped. Reset empties the stack and clears
// the overflow flag and the output valid flag. While out_stall is high the
// held request stays unchanged and the sequencer waits before producing the
// next character; a character that emits nothing still proceeds.
module infix_to_postfix_converter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itpc_pkg::out_item_t out_data
);

  itpc_pkg::state_t    state_r, state_nxt;
  logic [7:0]          tok_r;
  logic                end_r;
  itpc_pkg::cnt_t      count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                emitted_r, emitted_nxt;
  logic                out_valid_r;
  itpc_pkg::out_item_t out_item_r;

  itpc_pkg::stk_ctl_t  stk_ctl;
  logic [7:0]          top_char;
  logic [7:0]          second_char;

  logic                accept;
  logic                slot_free;
  logic                cnt_nz;
  logic                full;
  logic                top_open;
  logic                close_emit;
  logic                oper_pop;
  logic                emit;
  itpc_pkg::out_item_t emit_item;

  itpc_stack u_stack (
    .clk         (clk),
    .ctl         (stk_ctl),
    .push_char   (tok_r),
    .top_char    (top_char),
    .second_char (second_char)
  );

  assign in_stall = (state_r != itpc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    slot_free  = !out_valid_r || !out_stall;
    cnt_nz     = (count_r != '0);
    full       = (count_r == itpc_pkg::CNT_W'(itpc_pkg::STACK_DEPTH));
    top_open   = (top_char == itpc_pkg::CH_OPEN);
    close_emit = cnt_nz && !top_open;
    oper_pop   = cnt_nz && !top_open &&
                 (itpc_pkg::rank_of(tok_r) <= itpc_pkg::rank_of(top_char));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itpc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = itpc_pkg::S_WORK;
        end
      end
      itpc_pkg::S_WORK: begin
        logic done;
        done = 1'b0;
        if (tok_r == itpc_pkg::CH_OPERAND) begin
          done = slot_free;
        end else if (tok_r == itpc_pkg::CH_OPEN) begin
          done = 1'b1;
        end else if (tok_r == itpc_pkg::CH_CLOSE) begin
          done = !close_emit;
        end else begin
          done = !oper_pop;
        end
        if (done) begin
          state_nxt = end_r ? itpc_pkg::S_FLUSH : itpc_pkg::S_IDLE;
        end
      end
      itpc_pkg::S_FLUSH: begin
        if (!cnt_nz && (emitted_r || slot_free)) begin
          state_nxt = itpc_pkg::S_IDLE;
        end
      end
      default: state_nxt = itpc_pkg::S_IDLE;
    endcase
  end

  // Stack operations and emitted characters.
  always_comb begin
    emit        = 1'b0;
    emit_item   = '0;
    stk_ctl     = '0;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    emitted_nxt = emitted_r;
    emit_item.overflow = ovf_r;
    case (state_r)
      itpc_pkg::S_IDLE: begin
        if (accept) begin
          emitted_nxt = 1'b0;
        end
      end
      itpc_pkg::S_WORK: begin
        if (tok_r == itpc_pkg::CH_OPERAND) begin
          if (slot_free) begin
            emit                   = 1'b1;
            emit_item.postfix_char = tok_r;
            emit_item.last         = end_r && !cnt_nz;
          end
        end else if (tok_r == itpc_pkg::CH_CLOSE) begin
          if (close_emit) begin
            if (slot_free) begin
              emit                   = 1'b1;
              emit_item.postfix_char = top_char;
              // Last only if nothing remains once a matching open bracket is dropped.
              emit_item.last = end_r &&
                ((count_r == itpc_pkg::CNT_W'(1)) ||
                 ((count_r == itpc_pkg::CNT_W'(2)) && (second_char == itpc_pkg::CH_OPEN)));
              stk_ctl.pop = 1'b1;
              count_nxt   = count_r - itpc_pkg::CNT_W'(1);
            end
          end else if (cnt_nz) begin
            stk_ctl.pop = 1'b1;
            count_nxt   = count_r - itpc_pkg::CNT_W'(1);
          end
        end else if ((tok_r != itpc_pkg::CH_OPEN) && oper_pop) begin
          if (slot_free) begin
            emit                   = 1'b1;
            emit_item.postfix_char = top_char;
            stk_ctl.pop            = 1'b1;
            count_nxt              = count_r - itpc_pkg::CNT_W'(1);
          end
        end else begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            stk_ctl.push = 1'b1;
            count_nxt    = count_r + itpc_pkg::CNT_W'(1);
          end
        end
      end
      itpc_pkg::S_FLUSH: begin
        if (cnt_nz) begin
          if (slot_free) begin
            emit                   = 1'b1;
            emit_item.postfix_char = top_char;
            emit_item.last         = (count_r == itpc_pkg::CNT_W'(1));
            stk_ctl.pop            = 1'b1;
            count_nxt              = count_r - itpc_pkg::CNT_W'(1);
          end
        end else if (!emitted_r && slot_free) begin
          emit              = 1'b1;
          emit_item.no_char = 1'b1;
          emit_item.last    = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      emitted_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itpc_pkg::S_IDLE;
      end_r       <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      emitted_r <= emitted_nxt;
      if (accept) begin
        end_r <= in_data.end_of_expr;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r <= in_data.token;
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= itpc_pkg::CNT_W'(itpc_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == itpc_pkg::S_WORK))
    else $error("accepted request not processed");

  a_no_char_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_char) |-> (out_data.last && (out_data.postfix_char == 8'h00)))
    else $error("empty result not marked last");

endmodule
